FILE: rtl/core/sed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types for the string escape decoder: the request that the front
// end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package sed_pkg;

  typedef enum logic [1:0] {
    K_RAW,
    K_CP,
    K_MARK
  } kind_t;

  // K_RAW:  data[7:0] first byte, data[15:8] second byte when two is set
  // K_CP:   data holds the 32-bit code point accumulator
  // K_MARK: empty end-of-string marker
  typedef struct packed {
    kind_t       kind;
    logic        two;
    logic [31:0] data;
    logic        str_end;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/sed_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_front
// Escape parser: tracks the escape mode per source byte and turns each byte
// into at most one request for the back end (raw bytes, code point, marker).
// ----------------------------------------------------------------------------
module sed_front
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            q_push,
  output entry_t          q_wdata
);

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] OFS_DIG  = 8'h30;
  localparam logic [7:0] OFS_LOW  = 8'h57;
  localparam logic [7:0] OFS_UPP  = 8'h37;

  typedef enum logic [2:0] {
    M_PLAIN,
    M_ESC,
    M_XHEX,
    M_USTART,
    M_UFIX,
    M_UBRACE
  } mode_t;

  mode_t       mode, mode_next;
  logic [31:0] acc, acc_next;
  logic [1:0]  dcnt, dcnt_next;
  logic        zseen, zseen_next;

  logic        accept;
  logic [3:0]  hv;
  logic [7:0]  a8;
  logic [1:0]  rcnt;
  logic [7:0]  rb0, rb1;
  logic        cp_emit;
  logic [31:0] cp_val;

  function automatic logic [3:0] hexval(input logic [7:0] b);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (b >= 8'h30 && b <= 8'h39) begin
        d = b - OFS_DIG;
      end else if (b >= 8'h61 && b <= 8'h66) begin
        d = b - OFS_LOW;
      end else if (b >= 8'h41 && b <= 8'h46) begin
        d = b - OFS_UPP;
      end
      return d[3:0];
    end
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hv       = hexval(in_byte);
  assign a8       = {acc[3:0], hv};

  always_comb begin
    mode_next  = mode;
    acc_next   = acc;
    dcnt_next  = dcnt;
    zseen_next = zseen;
    rcnt       = 2'd0;
    rb0        = 8'h00;
    rb1        = 8'h00;
    cp_emit    = 1'b0;
    cp_val     = acc;

    case (mode)
      M_ESC: begin
        if (in_byte == CH_X) begin
          mode_next = M_XHEX;
          acc_next  = 32'd0;
          dcnt_next = 2'd0;
        end else begin
          zseen_next = 1'b0;
          if (in_byte == CH_U) begin
            mode_next = M_USTART;
            acc_next  = 32'd0;
            dcnt_next = 2'd0;
          end else begin
            rb0       = CH_BSL;
            rcnt      = 2'd1;
            mode_next = M_PLAIN;
            if (in_byte == CH_BSL) begin
              mode_next = M_ESC;
            end else begin
              rb1  = in_byte;
              rcnt = 2'd2;
            end
          end
        end
      end
      M_XHEX: begin
        acc_next = {24'd0, a8};
        if (dcnt == 2'd1) begin
          if (a8 == 8'h00) begin
            zseen_next = 1'b1;
          end else if (!zseen) begin
            rb0  = a8;
            rcnt = 2'd1;
          end
          dcnt_next = 2'd0;
          mode_next = M_PLAIN;
        end else begin
          dcnt_next = 2'd1;
        end
      end
      M_USTART: begin
        if (in_byte == CH_LBR) begin
          mode_next = M_UBRACE;
        end else begin
          acc_next  = {28'd0, hv};
          dcnt_next = 2'd1;
          mode_next = M_UFIX;
        end
      end
      M_UFIX: begin
        acc_next = {acc[27:0], hv};
        if (dcnt == 2'd3) begin
          cp_emit   = 1'b1;
          cp_val    = {acc[27:0], hv};
          dcnt_next = 2'd0;
          mode_next = M_PLAIN;
        end else begin
          dcnt_next = dcnt + 2'd1;
        end
      end
      M_UBRACE: begin
        if (in_byte == CH_RBR) begin
          cp_emit   = 1'b1;
          mode_next = M_PLAIN;
        end else begin
          acc_next = {acc[27:0], hv};
        end
      end
      default: begin
        mode_next = M_PLAIN;
        if (in_byte == CH_BSL) begin
          mode_next = M_ESC;
        end else begin
          zseen_next = 1'b0;
          rb0        = in_byte;
          rcnt       = 2'd1;
        end
      end
    endcase

    if (in_last) begin
      // trailing lone backslash is copied
      if (mode_next == M_ESC) begin
        if (rcnt == 2'd0) begin
          rb0 = CH_BSL;
        end else begin
          rb1 = CH_BSL;
        end
        rcnt = rcnt + 2'd1;
      end
      mode_next  = M_PLAIN;
      acc_next   = 32'd0;
      dcnt_next  = 2'd0;
      zseen_next = 1'b0;
    end
  end

  always_comb begin
    q_wdata.str_end = in_last;
    q_wdata.two     = (rcnt == 2'd2);
    if (cp_emit) begin
      q_wdata.kind = K_CP;
      q_wdata.data = cp_val;
    end else if (rcnt != 2'd0) begin
      q_wdata.kind = K_RAW;
      q_wdata.data = {16'd0, rb1, rb0};
    end else begin
      q_wdata.kind = K_MARK;
      q_wdata.data = 32'd0;
    end
    q_push = accept && (cp_emit || (rcnt != 2'd0) || in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_PLAIN;
      acc   <= 32'd0;
      dcnt  <= 2'd0;
      zseen <= 1'b0;
    end else if (accept) begin
      mode  <= mode_next;
      acc   <= acc_next;
      dcnt  <= dcnt_next;
      zseen <= zseen_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sed_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_queue
// Small request queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
module sed_queue
  import sed_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      wdata,
  output logic        full,
  input  wire logic   pop,
  output entry_t      rdata,
  output logic        empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sed_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sed_back
// Byte emitter: takes requests from the queue, UTF-8 encodes code points
// and sends one byte per cycle into the output register while the receiver takes results.
// ----------------------------------------------------------------------------
module sed_back
  import sed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  entry_t          q_rdata,
  output logic            q_pop,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            run_last,
  output logic            string_end
);

  localparam logic [31:0] CP_MAX = 32'h0010_FFFF;
  localparam logic [20:0] CP_REP = 21'h00_FFFD;

  entry_t      cur;
  logic        cur_vld;
  logic [1:0]  idx;

  logic [20:0] cp;
  logic [1:0]  n_m1;
  logic [7:0]  cp_b [4];
  logic [7:0]  byte_sel;
  logic        bval;
  logic        adv, fin;

  always_comb begin
    cp = (cur.data > CP_MAX) ? CP_REP : cur.data[20:0];
    cp_b[0] = 8'h00;
    cp_b[1] = 8'h00;
    cp_b[2] = 8'h00;
    cp_b[3] = 8'h00;
    n_m1    = 2'd0;
    if (cp < 21'h80) begin
      cp_b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      n_m1    = 2'd1;
      cp_b[0] = {3'b110, cp[10:6]};
      cp_b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h1_0000) begin
      n_m1    = 2'd2;
      cp_b[0] = {4'b1110, cp[15:12]};
      cp_b[1] = {2'b10, cp[11:6]};
      cp_b[2] = {2'b10, cp[5:0]};
    end else begin
      n_m1    = 2'd3;
      cp_b[0] = {5'b11110, cp[20:18]};
      cp_b[1] = {2'b10, cp[17:12]};
      cp_b[2] = {2'b10, cp[11:6]};
      cp_b[3] = {2'b10, cp[5:0]};
    end

    bval = 1'b1;
    case (cur.kind)
      K_RAW: begin
        byte_sel = idx[0] ? cur.data[15:8] : cur.data[7:0];
        n_m1     = {1'b0, cur.two};
      end
      K_CP: begin
        byte_sel = cp_b[idx];
      end
      default: begin
        byte_sel = 8'h00;
        bval     = 1'b0;
        n_m1     = 2'd0;
      end
    endcase
  end

  assign adv   = cur_vld && (!result_valid || result_ready);
  assign fin   = adv && (idx == n_m1);
  assign q_pop = !q_empty && (!cur_vld || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld      <= 1'b0;
      idx          <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        cur     <= q_rdata;
        cur_vld <= 1'b1;
        idx     <= 2'd0;
      end else if (fin) begin
        cur_vld <= 1'b0;
      end else if (adv) begin
        idx <= idx + 2'd1;
      end

      if (adv) begin
        result_valid <= 1'b1;
        out_byte     <= byte_sel;
        out_valid    <= bval;
        run_last     <= (idx == n_m1);
        string_end   <= (idx == n_m1) && cur.str_end;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/string_escape_to_utf8_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_escape_to_utf8_decoder
// Decodes the source bytes of a string literal (\xHH, \uHHHH, \u{...},
// backslash copies) into a stream of UTF-8 bytes.
//
// Input channel in_valid/in_ready carries one source byte per request with
// in_last on the final byte of a string. Result channel result_valid/
// result_ready carries one output byte per request; run_last marks the last
// byte caused by one input byte, string_end the last of the string, and a
// string whose last byte yields nothing ends with an empty marker
// (out_valid low, out_byte zero).
// One input byte is taken per cycle while the request queue has room
// (QUEUE_DEPTH entries). The emitter sends one byte per cycle while the
// receiver takes results; a code point yields 1 to 4 output bytes. Input
// passes the queue, request register and output register. A stalled
// receiver holds the output register; the queue fills, then in_ready
// drops. Reset empties the queue and returns the parser to plain text.
// ----------------------------------------------------------------------------
module string_escape_to_utf8_decoder
  import sed_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            run_last,
  output logic            string_end
);

  entry_t q_wdata, q_rdata;
  logic   q_push, q_pop, q_full, q_empty;

  sed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  sed_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .run_last     (run_last),
    .string_end   (string_end)
  );

endmodule
`default_nettype wire
